@@ hdl/monitor_packet_deframer_unit_defines.svh @@
// Assertion macros for the monitor packet deframer.
// Each macro expects signals clk and rst in the enclosing scope.
`ifndef MONITOR_PACKET_DEFRAMER_UNIT_DEFINES_SVH
`define MONITOR_PACKET_DEFRAMER_UNIT_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define MPD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that a condition implies another in the next cycle.
`define MPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/mpd_pkg.sv @@
package mpd_pkg;

  // Payload geometry
  localparam int FULL_PAYLOAD      = 107;
  localparam int NORMAL_LAST_INDEX = 42;
  localparam int STORE_DEPTH       = 11;
  localparam int IDX_W             = 7;
  localparam int STORE_IDX_W       = $clog2(STORE_DEPTH);

  // Idle limit register
  localparam int              LIMIT_W           = 16;
  localparam logic [LIMIT_W-1:0] IDLE_LIMIT_RESET = LIMIT_W'(100);
  localparam logic [LIMIT_W-1:0] IDLE_COUNT_MAX   = '1;

  // Header lengths (bits 7..1 of the header byte)
  localparam logic [6:0] LEN_IDENT  = 7'd4;
  localparam logic [6:0] LEN_RESET  = 7'd7;
  localparam logic [6:0] LEN_NORMAL = 7'd43;
  localparam logic [6:0] LEN_FULL   = 7'd108;

  // Header types (bit 0)
  localparam logic TYPE_CTRL = 1'b0;
  localparam logic TYPE_DATA = 1'b1;

  // Zero bytes that lead a frame
  localparam logic [1:0] START_ZEROS = 2'd2;

  // Input command codes
  typedef enum logic {
    CMD_BYTE = 1'b0,
    CMD_IDLE = 1'b1
  } cmd_t;

  // Result event codes
  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_IDENT = 2'd1,
    EV_RESET = 2'd2,
    EV_FRAME = 2'd3
  } event_t;

  // One input beat
  typedef struct packed {
    cmd_t       command;
    logic [7:0] rx_byte;
  } item_t;

  // One result beat
  typedef struct packed {
    event_t      event_res;
    logic [10:0] current_fps;
    logic [10:0] average_fps;
    logic [9:0]  low_percentile_fps;
    logic [7:0]  ram_use;
    logic [7:0]  cpu_temperature;
    logic [7:0]  cpu_load;
    logic [7:0]  gpu_temperature;
    logic [7:0]  gpu_load;
    logic [7:0]  mode_flags;
    logic [7:0]  vram_use;
    logic        full_frame;
  } result_t;

endpackage

@@ hdl/monitor_packet_deframer_unit.sv @@
// Monitor packet deframer. Each input beat is one received UART byte
// (s_tuser = 0) or one idle tick (s_tuser = 1), and every input beat yields
// exactly one result beat, passed from the input register to the result
// register. A new beat is accepted every cycle while the output is not
// stalled; the frame state between the two registers updates once per
// beat. Results carry an event code in m_tuser[1:0] (none, identity query,
// reset request, frame complete); the metric fields in m_tdata and
// the full-frame flag in m_tuser[2] are zero unless the event is frame
// complete. idle_limit (reset 100) is written through cfg_we/cfg_wdata
// and should only change while the block is idle.
`include "monitor_packet_deframer_unit_defines.svh"

module monitor_packet_deframer_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [mpd_pkg::LIMIT_W-1:0]  cfg_wdata,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [7:0]                   s_tdata,  // [7:0] rx_byte
  input  logic                         s_tuser,  // [0] command
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // [10:0] current_fps, [21:11] average_fps, [31:22] low_percentile_fps,
  // [39:32] ram_use, [47:40] cpu_temperature, [55:48] cpu_load,
  // [63:56] gpu_temperature, [71:64] gpu_load, [79:72] mode_flags,
  // [87:80] vram_use
  output logic [87:0]                  m_tdata,
  output logic [2:0]                   m_tuser   // [1:0] event_res, [2] full_frame
);

  logic             advance;
  logic             item_valid;
  mpd_pkg::item_t   item;
  mpd_pkg::result_t result;

  // Result register frees when empty or taken
  assign advance = !m_tvalid || m_tready;

  mpd_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  mpd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fire      (item_valid && advance),
    .item      (item),
    .result    (result)
  );

  // Result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= item_valid;
    end
  end

  // Pack and hold the result beat
  always_ff @(posedge clk) begin
    if (advance && item_valid) begin
      m_tdata <= {result.vram_use, result.mode_flags, result.gpu_load,
                  result.gpu_temperature, result.cpu_load, result.cpu_temperature,
                  result.ram_use, result.low_percentile_fps, result.average_fps,
                  result.current_fps};
      m_tuser <= {result.full_frame, result.event_res};
    end
  end

  // Metrics only travel with a completed frame
  `MPD_ASSERT_SAME(a_metrics_zero, m_tvalid && m_tuser[1:0] != mpd_pkg::EV_FRAME, m_tdata == '0 && !m_tuser[2], "metric fields set without frame event")
  // An empty result register never blocks the input
  `MPD_ASSERT_SAME(a_ready_when_empty, !m_tvalid, s_tready, "input stalled with empty output")
  // Output drains when nothing waits behind it
  `MPD_ASSERT_NEXT(a_drain, m_tvalid && m_tready && !item_valid, !m_tvalid, "stale result beat repeated")

endmodule

@@ hdl/mpd_in_reg.sv @@
module mpd_in_reg (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [7:0]      s_tdata,   // [7:0] rx_byte
  input  logic            s_tuser,   // [0] command
  input  logic            advance,
  output logic            item_valid,
  output mpd_pkg::item_t  item
);

  // Take a new beat when none is held or the held one moves on
  assign s_tready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  // Hold the payload of the accepted beat
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.command <= mpd_pkg::cmd_t'(s_tuser);
      item.rx_byte <= s_tdata;
    end
  end

endmodule

@@ hdl/mpd_core.sv @@
module mpd_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [mpd_pkg::LIMIT_W-1:0]   cfg_wdata,
  input  logic                          fire,
  input  mpd_pkg::item_t                item,
  output mpd_pkg::result_t              result
);

  logic [mpd_pkg::LIMIT_W-1:0] idle_limit;
  logic [1:0]                  zero_run, zero_run_next;
  logic                        receiving, receiving_next;
  logic                        full_mode, full_mode_next;
  logic [mpd_pkg::IDX_W-1:0]   write_index, write_index_next;
  logic [mpd_pkg::LIMIT_W-1:0] idle_count, idle_count_next;
  logic [7:0]                  metric_store [mpd_pkg::STORE_DEPTH];
  logic [7:0]                  store_next   [mpd_pkg::STORE_DEPTH];

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_limit <= mpd_pkg::IDLE_LIMIT_RESET;
    end else if (cfg_we) begin
      idle_limit <= cfg_wdata;
    end
  end

  // Decode one beat against the frame state
  always_comb begin
    logic                        done;
    logic                        had_data;
    logic [mpd_pkg::IDX_W-1:0]   idx_inc;
    logic [mpd_pkg::LIMIT_W-1:0] idle_inc;
    logic [6:0]                  hdr_len;
    logic                        hdr_type;

    zero_run_next    = zero_run;
    receiving_next   = receiving;
    full_mode_next   = full_mode;
    write_index_next = write_index;
    idle_count_next  = idle_count;
    store_next       = metric_store;
    done             = 1'b0;
    had_data         = (write_index != '0);
    idx_inc          = write_index + mpd_pkg::IDX_W'(1);
    idle_inc         = idle_count;
    hdr_len          = item.rx_byte[7:1];
    hdr_type         = item.rx_byte[0];
    result           = '0;
    result.event_res = mpd_pkg::EV_NONE;

    if (item.command == mpd_pkg::CMD_IDLE) begin
      // Idle tick: a normal frame ends at once, a full one after the limit
      if (!full_mode) begin
        done = 1'b1;
      end else begin
        if (idle_count != mpd_pkg::IDLE_COUNT_MAX) begin
          idle_inc = idle_count + mpd_pkg::LIMIT_W'(1);
        end
        idle_count_next = idle_inc;
        if (idle_inc >= idle_limit) begin
          done = 1'b1;
        end
      end
    end else if (receiving) begin
      // Payload byte: store the metric slots, advance the index
      idle_count_next = '0;
      if (write_index < mpd_pkg::IDX_W'(mpd_pkg::STORE_DEPTH)) begin
        store_next[write_index[mpd_pkg::STORE_IDX_W-1:0]] = item.rx_byte;
      end
      if (!full_mode && idx_inc > mpd_pkg::IDX_W'(mpd_pkg::NORMAL_LAST_INDEX)) begin
        idx_inc = mpd_pkg::IDX_W'(mpd_pkg::NORMAL_LAST_INDEX);
      end
      write_index_next = idx_inc;
      if (full_mode && idx_inc >= mpd_pkg::IDX_W'(mpd_pkg::FULL_PAYLOAD)) begin
        done = 1'b1;
      end
      had_data = 1'b1;
    end else if (zero_run == mpd_pkg::START_ZEROS) begin
      // Header byte
      if (hdr_len == mpd_pkg::LEN_IDENT && hdr_type == mpd_pkg::TYPE_CTRL) begin
        zero_run_next    = '0;
        result.event_res = mpd_pkg::EV_IDENT;
      end else if (hdr_len == mpd_pkg::LEN_RESET && hdr_type == mpd_pkg::TYPE_CTRL) begin
        zero_run_next    = '0;
        receiving_next   = 1'b0;
        full_mode_next   = 1'b0;
        write_index_next = '0;
        idle_count_next  = '0;
        for (int i = 0; i < mpd_pkg::STORE_DEPTH; i++) begin
          store_next[i] = '0;
        end
        result.event_res = mpd_pkg::EV_RESET;
      end else if (hdr_len == mpd_pkg::LEN_NORMAL && hdr_type == mpd_pkg::TYPE_DATA) begin
        receiving_next  = 1'b1;
        idle_count_next = '0;
      end else if (hdr_len == mpd_pkg::LEN_FULL && hdr_type == mpd_pkg::TYPE_DATA) begin
        receiving_next  = 1'b1;
        full_mode_next  = 1'b1;
        idle_count_next = '0;
      end else begin
        zero_run_next = '0;
      end
    end else if (item.rx_byte == 8'h00) begin
      zero_run_next = zero_run + 2'd1;
    end else begin
      zero_run_next = '0;
    end

    // Frame end: unpack metrics, close the session
    if (done) begin
      if (had_data) begin
        result.event_res          = mpd_pkg::EV_FRAME;
        result.current_fps        = {store_next[0], store_next[1][7:5]};
        result.average_fps        = {store_next[1][4:0], store_next[2][7:2]};
        result.low_percentile_fps = {store_next[2][1:0], store_next[3]};
        result.ram_use            = store_next[4];
        result.cpu_temperature    = store_next[5];
        result.cpu_load           = store_next[6];
        result.gpu_temperature    = store_next[7];
        result.gpu_load           = store_next[8];
        result.mode_flags         = store_next[9];
        result.vram_use           = store_next[10];
        result.full_frame         = full_mode;
      end
      zero_run_next    = '0;
      receiving_next   = 1'b0;
      full_mode_next   = 1'b0;
      write_index_next = '0;
      idle_count_next  = '0;
    end
  end

  // Commit state when a beat is processed
  always_ff @(posedge clk) begin
    if (rst) begin
      zero_run    <= '0;
      receiving   <= 1'b0;
      full_mode   <= 1'b0;
      write_index <= '0;
      idle_count  <= '0;
      for (int i = 0; i < mpd_pkg::STORE_DEPTH; i++) begin
        metric_store[i] <= '0;
      end
    end else if (fire) begin
      zero_run     <= zero_run_next;
      receiving    <= receiving_next;
      full_mode    <= full_mode_next;
      write_index  <= write_index_next;
      idle_count   <= idle_count_next;
      metric_store <= store_next;
    end
  end

endmodule
